@@ hw/rtl/c_subset_tokenizer_top_macros.svh @@
// ----------------------------------------------------------------------------
// c_subset_tokenizer_top_macros
// assertion macros shared by the tokenizer modules
// ----------------------------------------------------------------------------
`ifndef C_SUBSET_TOKENIZER_TOP_MACROS_SVH
`define C_SUBSET_TOKENIZER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define CST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// types, token codes and character classes of the c subset tokenizer
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int MAX_IDENT_LEN = 32;
	localparam int INT_WIDTH     = 32;
	localparam int IDX_W         = $clog2(MAX_IDENT_LEN);
	localparam int LEN_W         = $clog2(MAX_IDENT_LEN + 2);
	localparam int KW_LEN        = 6;

	localparam logic [4:0] TK_EOF    = 5'd0;
	localparam logic [4:0] TK_IDCHAR = 5'd1;
	localparam logic [4:0] TK_RETURN = 5'd2;
	localparam logic [4:0] TK_INT    = 5'd3;
	localparam logic [4:0] TK_LPAREN = 5'd4;
	localparam logic [4:0] TK_RPAREN = 5'd5;
	localparam logic [4:0] TK_LBRACE = 5'd6;
	localparam logic [4:0] TK_RBRACE = 5'd7;
	localparam logic [4:0] TK_COMMA  = 5'd8;
	localparam logic [4:0] TK_PLUS   = 5'd9;
	localparam logic [4:0] TK_STAR   = 5'd10;
	localparam logic [4:0] TK_SEMI   = 5'd11;
	localparam logic [4:0] TK_GT     = 5'd12;
	localparam logic [4:0] TK_LT     = 5'd13;
	localparam logic [4:0] TK_ASSIGN = 5'd14;
	localparam logic [4:0] TK_EQ     = 5'd15;
	localparam logic [4:0] TK_BAD    = 5'd16;
	localparam logic [4:0] TK_LONG   = 5'd17;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_UNDER = 8'h5f;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_INT     = 3'd2,
		MODE_EQ      = 3'd3,
		MODE_DISCARD = 3'd4
	} cst_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_READ,
		ST_CHAR,
		ST_FRESH
	} cst_state_t;

	// what ends with the current word before it is lexed on its own
	typedef enum logic [1:0] {
		PLAN_NONE,
		PLAN_ONE,
		PLAN_CHARS
	} cst_plan_t;

	typedef struct packed {
		logic load_ch;
		logic extend;
		logic flush_commit;
		logic rd_start;
		logic rd_issue;
		logic char_emit;
		logic fresh_commit;
	} cst_cmd_t;

	typedef struct packed {
		cst_plan_t plan;
		logic      fresh_run;
		logic      fresh_emit;
		logic      char_done;
		logic      out_free;
	} cst_status_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_ident_char(input logic [7:0] c);
		return is_letter(c) || is_digit(c) || c == CH_UNDER;
	endfunction

	// TK_EOF means not a single-character symbol
	function automatic logic [4:0] symbol_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			"{":     k = TK_LBRACE;
			"}":     k = TK_RBRACE;
			",":     k = TK_COMMA;
			"+":     k = TK_PLUS;
			"*":     k = TK_STAR;
			";":     k = TK_SEMI;
			">":     k = TK_GT;
			"<":     k = TK_LT;
			default: k = TK_EOF;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = "r";
			3'd1:    c = "e";
			3'd2:    c = "t";
			3'd3:    c = "u";
			3'd4:    c = "r";
			3'd5:    c = "n";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] int_out(input logic [INT_WIDTH-1:0] a);
		logic [63:0] w;
		w = 64'(a);
		return w[31:0];
	endfunction

endpackage

@@ hw/rtl/c_subset_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// c_subset_tokenizer_top
// byte-serial lexer for a small c subset
// ----------------------------------------------------------------------------
// Takes one source byte per input word (byte 0 ends the source) and returns
// token words on the output channel; the last word caused by an input byte
// carries run_last. A byte that extends an identifier or integer, completes
// '==', or is dropped after an error passes through accept and decode only.
// Every other byte, whitespace between tokens included, also passes through
// a fresh-lex step that lexes it from between tokens. When an identifier
// ends, its characters are replayed from the identifier buffer, each read
// before it is sent, as the buffer has a single registered read port. Each
// result also waits for the one-deep output register to be free.

module c_subset_tokenizer_top import cst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [31:0] int_value,
	output logic [7:0]  char_out,
	output logic        run_last
);

	cst_cmd_t    cmd;
	cst_status_t status;

	cst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	cst_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ch         (ch),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.token_kind (token_kind),
		.int_value  (int_value),
		.char_out   (char_out),
		.run_last   (run_last)
	);

endmodule

@@ hw/rtl/cst_ctrl.sv @@
// ----------------------------------------------------------------------------
// cst_ctrl
// sequencer: takes a word, then steps flush, identifier replay and fresh lex
// ----------------------------------------------------------------------------
`include "c_subset_tokenizer_top_macros.svh"

module cst_ctrl import cst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cst_status_t status,
	output cst_cmd_t    cmd
);

	cst_state_t state_q;
	cst_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				unique case (status.plan)
					PLAN_ONE: begin
						if (status.out_free) state_d = status.fresh_run ? ST_FRESH : ST_IDLE;
					end
					PLAN_CHARS: state_d = ST_READ;
					default:    state_d = status.fresh_run ? ST_FRESH : ST_IDLE;
				endcase
			end
			ST_READ: state_d = ST_CHAR;
			ST_CHAR: begin
				if (status.out_free) state_d = status.char_done ? ST_FRESH : ST_READ;
			end
			ST_FRESH: begin
				if (!status.fresh_emit || status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_ch = in_valid;
			end
			ST_DECIDE: begin
				unique case (status.plan)
					PLAN_ONE:   cmd.flush_commit = status.out_free;
					PLAN_CHARS: cmd.rd_start     = 1'b1;
					default:    cmd.extend       = !status.fresh_run;
				endcase
			end
			ST_READ:  cmd.rd_issue = 1'b1;
			ST_CHAR:  cmd.char_emit = status.out_free;
			ST_FRESH: cmd.fresh_commit = !status.fresh_emit || status.out_free;
			default: ;
		endcase
	end

	`CST_ASSERT_NEXT(a_accept_decide, clk, arst_n, in_valid && in_ready, state_q == ST_DECIDE, "accepted word did not go to decode")
	`CST_ASSERT_NEXT(a_read_then_char, clk, arst_n, state_q == ST_READ, state_q == ST_CHAR, "buffer read not followed by character")
	`CST_ASSERT_SAME(a_emit_free, clk, arst_n, cmd.flush_commit || cmd.char_emit || (cmd.fresh_commit && status.fresh_emit), status.out_free, "result issued while output register busy")

endmodule

@@ hw/rtl/cst_datapath.sv @@
// ----------------------------------------------------------------------------
// cst_datapath
// lexer state, identifier buffer, integer accumulator and output register
// ----------------------------------------------------------------------------
`include "c_subset_tokenizer_top_macros.svh"

module cst_datapath import cst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  ch,
	input  cst_cmd_t    cmd,
	output cst_status_t status,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [31:0] int_value,
	output logic [7:0]  char_out,
	output logic        run_last
);

	logic [7:0]           ch_q;
	cst_mode_t            mode_q;
	logic [LEN_W-1:0]     len_q;
	logic [INT_WIDTH-1:0] acc_q;
	logic                 match_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [7:0]           rd_data_q;
	logic [7:0]           ident_mem [MAX_IDENT_LEN];

	logic                 out_valid_q;
	logic [4:0]           kind_q;
	logic [31:0]          value_q;
	logic [7:0]           char_q;
	logic                 last_q;

	logic                 c_letter, c_digit, c_space, c_under, c_eq, c_nul, c_sym, c_bad;
	logic [4:0]           sym_kind;
	logic                 fresh_emit;
	logic                 fresh_run;
	cst_plan_t            plan;
	logic [4:0]           flush_kind;
	logic                 char_done;
	logic                 out_free;
	logic                 len_room;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic                 emit;
	logic [INT_WIDTH-1:0] acc_next;

	// character classes of the held word
	always_comb begin
		c_letter   = is_letter(ch_q);
		c_digit    = is_digit(ch_q);
		c_space    = is_space(ch_q);
		c_under    = ch_q == CH_UNDER;
		c_eq       = ch_q == CH_EQ;
		c_nul      = ch_q == CH_NUL;
		sym_kind   = symbol_kind(ch_q);
		c_sym      = sym_kind != TK_EOF;
		c_bad      = !(c_nul || c_space || c_letter || c_under || c_digit || c_eq || c_sym);
		fresh_emit = c_nul || c_sym || c_bad;
	end

	always_comb begin
		plan       = PLAN_NONE;
		fresh_run  = 1'b1;
		flush_kind = TK_EOF;
		unique case (mode_q)
			MODE_IDENT: begin
				if (is_ident_char(ch_q)) begin
					fresh_run = 1'b0;
				end else if (len_q > LEN_W'(MAX_IDENT_LEN)) begin
					plan       = PLAN_ONE;
					flush_kind = TK_LONG;
				end else if (len_q == LEN_W'(KW_LEN) && match_q) begin
					plan       = PLAN_ONE;
					flush_kind = TK_RETURN;
				end else begin
					plan = PLAN_CHARS;
				end
			end
			MODE_INT: begin
				if (c_digit) begin
					fresh_run = 1'b0;
				end else begin
					plan       = PLAN_ONE;
					flush_kind = TK_INT;
				end
			end
			MODE_EQ: begin
				plan       = PLAN_ONE;
				flush_kind = c_eq ? TK_EQ : TK_ASSIGN;
				fresh_run  = !c_eq;
			end
			MODE_DISCARD: fresh_run = c_nul;
			default: ;
		endcase
	end

	assign char_done = (LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q;
	assign out_free  = !out_valid_q || out_ready;
	assign len_room  = len_q < LEN_W'(MAX_IDENT_LEN);
	// times ten as two shifted adds
	assign acc_next  = (acc_q << 3) + (acc_q << 1) + INT_WIDTH'(ch_q[3:0]);

	always_comb begin
		status.plan       = plan;
		status.fresh_run  = fresh_run;
		status.fresh_emit = fresh_emit;
		status.char_done  = char_done;
		status.out_free   = out_free;
	end

	// identifier buffer, one write and one registered read port
	assign wr_en   = (cmd.extend && mode_q == MODE_IDENT && len_room)
		|| (cmd.fresh_commit && (c_letter || c_under));
	assign wr_addr = cmd.fresh_commit ? '0 : len_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) ident_mem[wr_addr] <= ch_q;
		if (cmd.rd_issue) rd_data_q <= ident_mem[rd_idx_q];
		if (cmd.load_ch) ch_q <= ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			len_q    <= '0;
			acc_q    <= '0;
			match_q  <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.extend) begin
				if (mode_q == MODE_IDENT) begin
					if (len_q <= LEN_W'(MAX_IDENT_LEN)) len_q <= len_q + LEN_W'(1);
					match_q <= match_q && len_q < LEN_W'(KW_LEN) && ch_q == kw_char(len_q[2:0]);
				end else if (mode_q == MODE_INT) begin
					acc_q <= acc_next;
				end
			end
			if (cmd.flush_commit) begin
				mode_q <= MODE_IDLE;
				acc_q  <= '0;
				len_q  <= '0;
			end
			if (cmd.rd_start) rd_idx_q <= '0;
			if (cmd.char_emit) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
				if (char_done) begin
					mode_q <= MODE_IDLE;
					len_q  <= '0;
				end
			end
			if (cmd.fresh_commit) begin
				if (c_nul) begin
					mode_q <= MODE_IDLE;
					len_q  <= '0;
					acc_q  <= '0;
				end else if (c_space || c_sym) begin
					mode_q <= MODE_IDLE;
				end else if (c_letter || c_under) begin
					mode_q  <= MODE_IDENT;
					len_q   <= LEN_W'(1);
					match_q <= ch_q == kw_char(3'd0);
				end else if (c_digit) begin
					mode_q <= MODE_INT;
					acc_q  <= INT_WIDTH'(ch_q[3:0]);
				end else if (c_eq) begin
					mode_q <= MODE_EQ;
				end else begin
					mode_q <= MODE_DISCARD;
				end
			end
		end
	end

	// output register
	assign emit = cmd.flush_commit || cmd.char_emit || (cmd.fresh_commit && fresh_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush_commit) begin
			kind_q  <= flush_kind;
			value_q <= (flush_kind == TK_INT) ? int_out(acc_q) : 32'd0;
			char_q  <= CH_NUL;
			last_q  <= !(fresh_run && fresh_emit);
		end else if (cmd.char_emit) begin
			kind_q  <= TK_IDCHAR;
			value_q <= 32'd0;
			char_q  <= rd_data_q;
			last_q  <= char_done && !fresh_emit;
		end else if (cmd.fresh_commit && fresh_emit) begin
			kind_q  <= c_nul ? TK_EOF : (c_sym ? sym_kind : TK_BAD);
			value_q <= 32'd0;
			char_q  <= c_bad ? ch_q : CH_NUL;
			last_q  <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign token_kind = kind_q;
	assign int_value  = value_q;
	assign char_out   = char_q;
	assign run_last   = last_q;

	`CST_ASSERT_SAME(a_len_bound, clk, arst_n, 1'b1, len_q <= LEN_W'(MAX_IDENT_LEN + 1), "identifier length past saturation")
	`CST_ASSERT_SAME(a_ident_nonempty, clk, arst_n, mode_q == MODE_IDENT, len_q != '0, "identifier mode with empty buffer")
	`CST_ASSERT_SAME(a_replay_short, clk, arst_n, cmd.char_emit || cmd.rd_issue, len_q <= LEN_W'(MAX_IDENT_LEN), "replay of an overlong identifier")

endmodule
